FILE: hdl/off_frame_sensor_read_sequencer_macros.svh
// Assertion macros shared by the checker of the off-frame sensor read sequencer.
// No dependencies; the including module must provide clk and rst_n.
`ifndef OFF_FRAME_SENSOR_READ_SEQUENCER_MACROS_SVH
`define OFF_FRAME_SENSOR_READ_SEQUENCER_MACROS_SVH

// Checked only while the block is out of reset.
`define OFSRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define OFSRS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ofsrs_pkg.sv
// Package for the off-frame sensor read sequencer: command frames, codes and CRC-8.
// No dependencies; used by the top level and its checker.
package ofsrs_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_READ,
    MODE_DIAG
  } mode_t;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_CRC      = 3'd1,
    RC_FLAGS    = 3'd2,
    RC_NOTREADY = 3'd3,
    RC_UNEXP    = 3'd4
  } result_code_t;

  localparam logic [31:0] CMD_ACC_X   = 32'h040000F7;
  localparam logic [31:0] CMD_ACC_Y   = 32'h080000FD;
  localparam logic [31:0] CMD_TEMP    = 32'h140000EF;
  localparam logic [31:0] CMD_STATUS  = 32'h180000E5;
  localparam logic [31:0] CMD_ERR_ONE = 32'h1C0000E3;
  localparam logic [31:0] CMD_ERR_TWO = 32'h200000C1;

  localparam logic [7:0]  CRC_POLY  = 8'h1D;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [1:0]  RS_OK     = 2'h1;
  localparam logic [15:0] STATUS_OK = 16'h0001;
  localparam logic [1:0]  LAST_REPLY = 2'd3;

  localparam int CRC_BITS = 24;

  typedef logic [7:0] crc_col_t [CRC_BITS];

  // Bit-serial CRC-8, used only to build the constant tables below.
  function automatic logic [7:0] crc8_serial(input logic [CRC_BITS-1:0] d);
    logic [7:0] crc;
    logic       top;
    crc = CRC_INIT;
    for (int i = CRC_BITS - 1; i >= 0; i--) begin
      top = crc[7] ^ d[i];
      crc = {crc[6:0], 1'b0};
      if (top) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return ~crc;
  endfunction

  function automatic crc_col_t crc8_columns();
    crc_col_t cols;
    logic [7:0] base;
    base = crc8_serial('0);
    for (int i = 0; i < CRC_BITS; i++) begin
      cols[i] = crc8_serial(CRC_BITS'(1) << i) ^ base;
    end
    return cols;
  endfunction

  localparam logic [7:0] CRC_BASE = crc8_serial('0);
  localparam crc_col_t   CRC_COL  = crc8_columns();

  // The CRC is affine in the data, so each set bit contributes one constant column.
  function automatic logic [7:0] crc8_calc(input logic [CRC_BITS-1:0] d);
    logic [7:0] crc;
    crc = CRC_BASE;
    for (int i = 0; i < CRC_BITS; i++) begin
      if (d[i]) begin
        crc = crc ^ CRC_COL[i];
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] seq_cmd(input logic diag, input logic [1:0] idx);
    logic [31:0] cmd;
    case (idx)
      2'd1:    cmd = diag ? CMD_ERR_ONE : CMD_ACC_Y;
      2'd2:    cmd = diag ? CMD_ERR_TWO : CMD_TEMP;
      default: cmd = diag ? CMD_STATUS  : CMD_ACC_X;
    endcase
    return cmd;
  endfunction

endpackage

FILE: hdl/off_frame_sensor_read_sequencer.sv
// Top level of the off-frame sensor read sequencer: input register, step logic, result register.
// Depends on ofsrs_pkg for command frames, result codes and the CRC-8 function.
//
// Usage. A transaction on the in_ channel is either a start (in_kind 0) or a
// reply frame just received from the sensor (in_kind 1). Every input
// transaction yields exactly one result transaction on the out_ channel; when
// out_send_valid is set, out_command is the next frame to clock out on SPI.
// A result with out_done_res set ends the measurement and carries the code and
// the raw samples. The cfg_ channel writes sensor_ready; it is always ready and
// should only be written while no transaction is in flight.
// An accepted transaction goes from the input register through the step logic into the result register.
// One transaction is accepted per cycle while the receiver does not stall; the combinational step between the
// input register and the result register sets that rate.
// When the receiver stalls, the result is held and one further transaction
// may wait in the input register before in_stall is raised.
// Synchronous reset empties both registers, returns the sequencer to idle,
// clears all held words and clears sensor_ready.
module off_frame_sensor_read_sequencer
  import ofsrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_sensor_ready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [31:0]        in_reply_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_send_valid,
  output logic [31:0]        out_command,
  output logic               out_done_res,
  output logic [2:0]         out_result_code,
  output logic signed [15:0] out_raw_x,
  output logic signed [15:0] out_raw_y,
  output logic signed [15:0] out_raw_temp,
  output logic [15:0]        out_status_flags,
  output logic [15:0]        out_error_flags_one,
  output logic [15:0]        out_error_flags_two
);

  logic        ready_r;
  logic        in_vld_r;
  logic        in_kind_r;
  logic [31:0] in_frame_r;
  logic        out_ready;
  logic        adv;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [15:0] held_x_r, held_x_nxt;
  logic [15:0] held_y_r, held_y_nxt;
  logic [15:0] held_temp_r, held_temp_nxt;
  logic [15:0] held_status_r, held_status_nxt;
  logic [15:0] held_err_one_r, held_err_one_nxt;
  logic [15:0] held_err_two_r, held_err_two_nxt;
  logic        crc_failed_r, crc_failed_nxt;
  logic        abn_r, abn_nxt;

  logic         res_send;
  logic [31:0]  res_cmd;
  logic         res_done;
  result_code_t res_code;
  logic         res_raw;
  logic         res_diag;
  logic [15:0]  data;
  logic [1:0]   rs;
  logic         crc_ok;

  logic         out_valid_r;
  logic         out_send_r;
  logic [31:0]  out_cmd_r;
  logic         out_done_r;
  result_code_t out_code_r;
  logic [15:0]  out_x_r;
  logic [15:0]  out_y_r;
  logic [15:0]  out_temp_r;
  logic [15:0]  out_status_r;
  logic [15:0]  out_err_one_r;
  logic [15:0]  out_err_two_r;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = in_vld_r && out_ready;
  assign in_stall  = in_vld_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      ready_r <= cfg_sensor_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_kind_r  <= in_kind;
      in_frame_r <= in_reply_frame;
    end
  end

  always_comb begin
    mode_nxt         = mode_r;
    idx_nxt          = idx_r;
    held_x_nxt       = held_x_r;
    held_y_nxt       = held_y_r;
    held_temp_nxt    = held_temp_r;
    held_status_nxt  = held_status_r;
    held_err_one_nxt = held_err_one_r;
    held_err_two_nxt = held_err_two_r;
    crc_failed_nxt   = crc_failed_r;
    abn_nxt          = abn_r;
    res_send         = 1'b0;
    res_cmd          = '0;
    res_done         = 1'b0;
    res_code         = RC_OK;
    res_raw          = 1'b0;
    res_diag         = 1'b0;
    data             = in_frame_r[23:8];
    rs               = in_frame_r[25:24];
    crc_ok           = crc8_calc(in_frame_r[31:8]) == in_frame_r[7:0];

    if (!in_kind_r) begin
      if (mode_r != MODE_IDLE) begin
        mode_nxt       = MODE_IDLE;
        idx_nxt        = '0;
        crc_failed_nxt = 1'b0;
        abn_nxt        = 1'b0;
        res_done       = 1'b1;
        res_code       = RC_UNEXP;
      end else if (!ready_r) begin
        res_done = 1'b1;
        res_code = RC_NOTREADY;
      end else begin
        mode_nxt         = MODE_READ;
        idx_nxt          = '0;
        crc_failed_nxt   = 1'b0;
        abn_nxt          = 1'b0;
        held_status_nxt  = '0;
        held_err_one_nxt = '0;
        held_err_two_nxt = '0;
        res_send         = 1'b1;
        res_cmd          = CMD_ACC_X;
      end
    end else if (mode_r == MODE_IDLE) begin
      res_done = 1'b1;
      res_code = RC_UNEXP;
    end else begin
      // The first reply of a pass answers an older command and is dropped.
      if (idx_r != '0) begin
        if (!crc_ok) begin
          crc_failed_nxt = 1'b1;
        end else if (mode_r == MODE_READ) begin
          case (idx_r)
            2'd1:    held_x_nxt    = data;
            2'd2:    held_y_nxt    = data;
            default: held_temp_nxt = data;
          endcase
          if (rs != RS_OK) begin
            abn_nxt = 1'b1;
          end
        end else begin
          case (idx_r)
            2'd1:    held_status_nxt  = data;
            2'd2:    held_err_one_nxt = data;
            default: held_err_two_nxt = data;
          endcase
        end
      end

      if (idx_r != LAST_REPLY) begin
        idx_nxt  = idx_r + 2'd1;
        res_send = 1'b1;
        res_cmd  = seq_cmd(mode_r == MODE_DIAG, idx_nxt);
      end else begin
        idx_nxt = '0;
        if (crc_failed_nxt) begin
          mode_nxt       = MODE_IDLE;
          crc_failed_nxt = 1'b0;
          abn_nxt        = 1'b0;
          res_done       = 1'b1;
          res_code       = RC_CRC;
        end else if (mode_r == MODE_READ) begin
          if (abn_nxt) begin
            mode_nxt = MODE_DIAG;
            abn_nxt  = 1'b0;
            res_send = 1'b1;
            res_cmd  = CMD_STATUS;
          end else begin
            mode_nxt = MODE_IDLE;
            res_done = 1'b1;
            res_raw  = 1'b1;
          end
        end else begin
          mode_nxt = MODE_IDLE;
          res_done = 1'b1;
          if (held_status_nxt == '0 || (held_status_nxt & ~STATUS_OK) != '0) begin
            res_code = RC_FLAGS;
            res_diag = 1'b1;
          end else begin
            res_raw  = 1'b1;
            res_diag = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      idx_r          <= '0;
      held_x_r       <= '0;
      held_y_r       <= '0;
      held_temp_r    <= '0;
      held_status_r  <= '0;
      held_err_one_r <= '0;
      held_err_two_r <= '0;
      crc_failed_r   <= 1'b0;
      abn_r          <= 1'b0;
    end else if (adv) begin
      mode_r         <= mode_nxt;
      idx_r          <= idx_nxt;
      held_x_r       <= held_x_nxt;
      held_y_r       <= held_y_nxt;
      held_temp_r    <= held_temp_nxt;
      held_status_r  <= held_status_nxt;
      held_err_one_r <= held_err_one_nxt;
      held_err_two_r <= held_err_two_nxt;
      crc_failed_r   <= crc_failed_nxt;
      abn_r          <= abn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_send_r    <= res_send;
      out_cmd_r     <= res_cmd;
      out_done_r    <= res_done;
      out_code_r    <= res_code;
      out_x_r       <= res_raw ? held_x_nxt : '0;
      out_y_r       <= res_raw ? held_y_nxt : '0;
      out_temp_r    <= res_raw ? held_temp_nxt : '0;
      out_status_r  <= res_diag ? held_status_nxt : '0;
      out_err_one_r <= res_diag ? held_err_one_nxt : '0;
      out_err_two_r <= res_diag ? held_err_two_nxt : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_send_valid      = out_send_r;
  assign out_command         = out_cmd_r;
  assign out_done_res        = out_done_r;
  assign out_result_code     = out_code_r;
  assign out_raw_x           = $signed(out_x_r);
  assign out_raw_y           = $signed(out_y_r);
  assign out_raw_temp        = $signed(out_temp_r);
  assign out_status_flags    = out_status_r;
  assign out_error_flags_one = out_err_one_r;
  assign out_error_flags_two = out_err_two_r;

endmodule

FILE: hdl/ofsrs_checker.sv
// Port-level checker for the off-frame sensor read sequencer, bound to the top level.
// Depends on ofsrs_pkg and off_frame_sensor_read_sequencer_macros.svh.
`include "off_frame_sensor_read_sequencer_macros.svh"

module ofsrs_checker
  import ofsrs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_send_valid,
  input logic [31:0]        out_command,
  input logic               out_done_res,
  input logic [2:0]         out_result_code,
  input logic signed [15:0] out_raw_x,
  input logic signed [15:0] out_raw_y,
  input logic signed [15:0] out_raw_temp
);

  `OFSRS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result pending after reset")

  `OFSRS_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_command), "stalled transaction changed")

  `OFSRS_ASSERT(a_done_no_send, out_valid && out_done_res |-> !out_send_valid, "final result also sends a command")

  `OFSRS_ASSERT(a_step_ok, out_valid && !out_done_res |-> out_send_valid && out_result_code == RC_OK, "intermediate transaction without command or with error code")

  `OFSRS_ASSERT(a_err_no_raw, out_valid && out_result_code != RC_OK |-> out_raw_x == '0 && out_raw_y == '0 && out_raw_temp == '0, "samples reported with an error code")

endmodule

bind off_frame_sensor_read_sequencer ofsrs_checker u_ofsrs_checker (.*);

FILE: test/ofsrs_checker.sv
// Checker for the off-frame sensor read sequencer: watches the cfg_, in_ and out_ channels,
// predicts every result transaction and compares it field by field with what the block sends.
// Depends on ofsrs_pkg for the command frames, CRC constants, modes and result codes.
module ofsrs_scoreboard
  import ofsrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_sensor_ready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic [31:0]        in_reply_frame,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_send_valid,
  input  logic [31:0]        out_command,
  input  logic               out_done_res,
  input  logic [2:0]         out_result_code,
  input  logic signed [15:0] out_raw_x,
  input  logic signed [15:0] out_raw_y,
  input  logic signed [15:0] out_raw_temp,
  input  logic [15:0]        out_status_flags,
  input  logic [15:0]        out_error_flags_one,
  input  logic [15:0]        out_error_flags_two,
  output int                 outstanding,
  output int                 fail_count
);

  typedef struct packed {
    logic         send;
    logic [31:0]  command;
    logic         done;
    result_code_t code;
    logic [15:0]  x;
    logic [15:0]  y;
    logic [15:0]  temp;
    logic [15:0]  status;
    logic [15:0]  err_one;
    logic [15:0]  err_two;
  } readout_t;

  localparam logic [3:0][31:0] READ_CMDS = {CMD_ACC_X, CMD_TEMP, CMD_ACC_Y, CMD_ACC_X};
  localparam logic [3:0][31:0] DIAG_CMDS = {CMD_STATUS, CMD_ERR_TWO, CMD_ERR_ONE, CMD_STATUS};

  mode_t       seq_mode;
  logic [1:0]  reply_pos;
  logic [15:0] x_word;
  logic [15:0] y_word;
  logic [15:0] temp_word;
  logic [15:0] status_word;
  logic [15:0] err_one_word;
  logic [15:0] err_two_word;
  logic        crc_seen;
  logic        abnormal_seen;
  logic        ready_bit;
  readout_t    pending_readouts[$];
  int          errors;

  initial begin
    errors = 0;
  end

  function automatic logic [7:0] reply_crc8(input logic [31:0] frame);
    logic [7:0] crc;
    logic       fb;
    crc = CRC_INIT;
    for (int i = 31; i > 7; i--) begin
      fb = crc[7] ^ frame[i];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return ~crc;
  endfunction

  function automatic readout_t step_sequencer(input logic kind, input logic [31:0] frame);
    readout_t    r;
    logic [15:0] data;
    r = '0;
    r.code = RC_OK;
    data = frame[23:8];
    if (!kind) begin
      r.done = 1'b1;
      if (seq_mode != MODE_IDLE) begin
        seq_mode = MODE_IDLE;
        reply_pos = '0;
        crc_seen = 1'b0;
        abnormal_seen = 1'b0;
        r.code = RC_UNEXP;
      end else if (!ready_bit) begin
        r.code = RC_NOTREADY;
      end else begin
        seq_mode = MODE_READ;
        reply_pos = '0;
        crc_seen = 1'b0;
        abnormal_seen = 1'b0;
        status_word = '0;
        err_one_word = '0;
        err_two_word = '0;
        r.done = 1'b0;
        r.send = 1'b1;
        r.command = CMD_ACC_X;
      end
      return r;
    end
    if (seq_mode == MODE_IDLE) begin
      r.done = 1'b1;
      r.code = RC_UNEXP;
      return r;
    end
    // The first reply of a pass answers an older command and is discarded.
    if (reply_pos != 2'd0) begin
      if (reply_crc8(frame) != frame[7:0]) begin
        crc_seen = 1'b1;
      end else if (seq_mode == MODE_READ) begin
        case (reply_pos)
          2'd1:    x_word = data;
          2'd2:    y_word = data;
          default: temp_word = data;
        endcase
        if (frame[25:24] != RS_OK) begin
          abnormal_seen = 1'b1;
        end
      end else begin
        case (reply_pos)
          2'd1:    status_word = data;
          2'd2:    err_one_word = data;
          default: err_two_word = data;
        endcase
      end
    end
    if (reply_pos != LAST_REPLY) begin
      reply_pos = reply_pos + 2'd1;
      r.send = 1'b1;
      r.command = (seq_mode == MODE_READ) ? READ_CMDS[reply_pos] : DIAG_CMDS[reply_pos];
      return r;
    end
    reply_pos = '0;
    r.done = 1'b1;
    if (crc_seen) begin
      seq_mode = MODE_IDLE;
      crc_seen = 1'b0;
      abnormal_seen = 1'b0;
      r.code = RC_CRC;
    end else if (seq_mode == MODE_READ && abnormal_seen) begin
      seq_mode = MODE_DIAG;
      abnormal_seen = 1'b0;
      r.done = 1'b0;
      r.send = 1'b1;
      r.command = CMD_STATUS;
    end else begin
      if (seq_mode == MODE_DIAG) begin
        r.status = status_word;
        r.err_one = err_one_word;
        r.err_two = err_two_word;
        if (status_word == '0 || (status_word & ~STATUS_OK) != '0) begin
          r.code = RC_FLAGS;
        end
      end
      if (r.code == RC_OK) begin
        r.x = x_word;
        r.y = y_word;
        r.temp = temp_word;
      end
      seq_mode = MODE_IDLE;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    readout_t want;
    if (!rst_n) begin
      seq_mode = MODE_IDLE;
      reply_pos = '0;
      x_word = '0;
      y_word = '0;
      temp_word = '0;
      status_word = '0;
      err_one_word = '0;
      err_two_word = '0;
      crc_seen = 1'b0;
      abnormal_seen = 1'b0;
      ready_bit = 1'b0;
      pending_readouts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        ready_bit = cfg_sensor_ready;
      end
      if (in_valid && !in_stall) begin
        pending_readouts.push_back(step_sequencer(in_kind, in_reply_frame));
      end
      if (out_valid && !out_stall) begin
        if (pending_readouts.size() == 0) begin
          $error("result transaction arrived with no prediction waiting");
          errors++;
        end else begin
          want = pending_readouts.pop_front();
          compare_field("send_valid", want.send, out_send_valid);
          compare_field("command", want.command, out_command);
          compare_field("done_res", want.done, out_done_res);
          compare_field("result_code", want.code, out_result_code);
          compare_field("raw_x", want.x, $unsigned(out_raw_x));
          compare_field("raw_y", want.y, $unsigned(out_raw_y));
          compare_field("raw_temp", want.temp, $unsigned(out_raw_temp));
          compare_field("status_flags", want.status, out_status_flags);
          compare_field("error_flags_one", want.err_one, out_error_flags_one);
          compare_field("error_flags_two", want.err_two, out_error_flags_two);
        end
      end
    end
    outstanding <= pending_readouts.size();
    fail_count <= errors;
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the off-frame sensor read sequencer: clock, reset, stimulus and verdict.
// Drives directed and random measurement sequences with random idling on both channels;
// depends on ofsrs_pkg, the block itself and ofsrs_scoreboard, which predicts and compares every result.
module tb_top
  import ofsrs_pkg::*;
();

  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_ITEMS  = 150;
  localparam int ABNORMAL_PCT = 20;
  localparam int CORRUPT_PCT  = 6;
  localparam int IDLE_PCT     = 34;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_sensor_ready = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = 1'b0;
  logic [31:0]        in_reply_frame = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_send_valid;
  logic [31:0]        out_command;
  logic               out_done_res;
  logic [2:0]         out_result_code;
  logic signed [15:0] out_raw_x;
  logic signed [15:0] out_raw_y;
  logic signed [15:0] out_raw_temp;
  logic [15:0]        out_status_flags;
  logic [15:0]        out_error_flags_one;
  logic [15:0]        out_error_flags_two;

  int   outstanding;
  int   fail_count;
  int   cycle_count;
  int   items_sent;
  int   measurements;
  int   diag_passes;
  int   noise_items;
  int   ready_writes;
  int   next_phase;
  int   random_end;
  logic quiet = 1'b0;

  off_frame_sensor_read_sequencer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sensor_ready    (cfg_sensor_ready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_reply_frame      (in_reply_frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_send_valid      (out_send_valid),
    .out_command         (out_command),
    .out_done_res        (out_done_res),
    .out_result_code     (out_result_code),
    .out_raw_x           (out_raw_x),
    .out_raw_y           (out_raw_y),
    .out_raw_temp        (out_raw_temp),
    .out_status_flags    (out_status_flags),
    .out_error_flags_one (out_error_flags_one),
    .out_error_flags_two (out_error_flags_two)
  );

  ofsrs_scoreboard i_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sensor_ready    (cfg_sensor_ready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_reply_frame      (in_reply_frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_send_valid      (out_send_valid),
    .out_command         (out_command),
    .out_done_res        (out_done_res),
    .out_result_code     (out_result_code),
    .out_raw_x           (out_raw_x),
    .out_raw_y           (out_raw_y),
    .out_raw_temp        (out_raw_temp),
    .out_status_flags    (out_status_flags),
    .out_error_flags_one (out_error_flags_one),
    .out_error_flags_two (out_error_flags_two),
    .outstanding         (outstanding),
    .fail_count          (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_item(input logic kind, input logic [31:0] frame);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_reply_frame <= frame;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_ready(input logic value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_sensor_ready <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ready_writes++;
  endtask

  function automatic logic [31:0] framed(input logic [1:0] rs, input logic [15:0] data,
                                         input logic corrupt);
    logic [23:0] body;
    logic [7:0]  crc;
    body = {6'($urandom), rs, data};
    crc = crc8_calc(body);
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(255, 1));
    end
    return {body, crc};
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_status();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1, 2:    return STATUS_OK;
      3:       return STATUS_OK | (16'h0001 << $urandom_range(15, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_measurement();
    logic [1:0] rs;
    logic       corrupt;
    logic       abnormal;
    logic       bad;
    abnormal = 1'b0;
    bad = 1'b0;
    measurements++;
    push_item(1'b0, $urandom);
    push_item(1'b1, $urandom);
    repeat (3) begin
      rs = ($urandom_range(99) < ABNORMAL_PCT) ? 2'($urandom_range(3)) : RS_OK;
      corrupt = $urandom_range(99) < CORRUPT_PCT;
      if (corrupt) begin
        bad = 1'b1;
      end else if (rs != RS_OK) begin
        abnormal = 1'b1;
      end
      push_item(1'b1, framed(rs, pick_word(), corrupt));
    end
    if (abnormal && !bad) begin
      diag_passes++;
      push_item(1'b1, $urandom);
      push_item(1'b1, framed(2'($urandom), pick_status(), $urandom_range(99) < CORRUPT_PCT));
      repeat (2) begin
        push_item(1'b1, framed(2'($urandom), pick_word(), $urandom_range(99) < CORRUPT_PCT));
      end
    end
  endtask

  task automatic make_noise();
    noise_items++;
    case ($urandom_range(3))
      0: push_item(1'($urandom), $urandom);
      1: begin
        push_item(1'b0, $urandom);
        repeat ($urandom_range(3)) push_item(1'b1, framed(RS_OK, pick_word(), 1'b0));
        push_item(1'b0, $urandom);
      end
      2: push_item(1'b1, $urandom);
      default: begin
        push_item(1'b0, $urandom);
        repeat (4) push_item(1'b1, $urandom);
      end
    endcase
  endtask

  initial begin
    items_sent = 0;
    measurements = 0;
    diag_passes = 0;
    noise_items = 0;
    ready_writes = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Refused start and a reply with no measurement running.
    write_ready(1'b0);
    push_item(1'b0, 32'hFFFF_FFFF);
    push_item(1'b1, 32'hFFFF_FFFF);
    write_ready(1'b1);

    // Clean read with extreme samples.
    push_item(1'b0, 32'h0000_0000);
    push_item(1'b1, 32'h0000_0000);
    push_item(1'b1, framed(RS_OK, 16'h8000, 1'b0));
    push_item(1'b1, framed(RS_OK, 16'h7FFF, 1'b0));
    push_item(1'b1, framed(RS_OK, 16'hFFFF, 1'b0));

    // A CRC error runs the pass to its end and suppresses the diagnostic pass.
    push_item(1'b0, 32'hFFFF_FFFF);
    push_item(1'b1, 32'hFFFF_FFFF);
    push_item(1'b1, framed(RS_OK, 16'h0000, 1'b0));
    push_item(1'b1, framed(RS_OK, 16'h1234, 1'b1));
    push_item(1'b1, framed(2'd0, 16'h5555, 1'b0));

    // Abnormal returns lead to a diagnostic pass; ready is cleared before its replies arrive.
    push_item(1'b0, 32'h0000_0000);
    push_item(1'b1, $urandom);
    push_item(1'b1, framed(2'd2, 16'h0001, 1'b0));
    push_item(1'b1, framed(2'd3, 16'hFFFE, 1'b0));
    push_item(1'b1, framed(RS_OK, 16'h00FF, 1'b0));
    write_ready(1'b0);
    push_item(1'b1, $urandom);
    push_item(1'b1, framed(2'd0, STATUS_OK, 1'b0));
    push_item(1'b1, framed(2'd3, 16'hFFFF, 1'b0));
    push_item(1'b1, framed(2'd0, 16'h0000, 1'b0));
    write_ready(1'b1);

    // A start while a read is running aborts it.
    push_item(1'b0, 32'h0000_0000);
    push_item(1'b1, $urandom);
    push_item(1'b0, 32'h0000_0000);

    random_end = items_sent + RANDOM_ITEMS;
    next_phase = items_sent + PHASE_ITEMS;
    while (items_sent < random_end) begin
      quiet = (items_sent > random_end - 700) && (items_sent < random_end - 400);
      if (items_sent >= next_phase) begin
        next_phase += PHASE_ITEMS;
        write_ready(1'b0);
        repeat ($urandom_range(6, 2)) push_item(1'($urandom), $urandom);
        write_ready(1'b1);
      end
      if ($urandom_range(49) == 0) begin
        wait_drained();
      end
      if ($urandom_range(99) < 80) begin
        run_measurement();
      end else begin
        make_noise();
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d transactions: %0d measurements, %0d diagnostic passes,",
             items_sent, measurements, diag_passes);
    $display("%0d noise sequences and %0d sensor_ready writes, with idling on both channels.",
             noise_items, ready_writes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ofsrs_pkg.sv
hdl/off_frame_sensor_read_sequencer.sv
hdl/ofsrs_checker.sv
test/ofsrs_checker.sv
test/tb_top.sv
